// ===== rtl/quaternion_vector_rotate_top_macros.svh =====
// Assertion macros for the quaternion vector rotate block.
// Used by the checker module; needs a clk and rst_n in scope.
`ifndef QUATERNION_VECTOR_ROTATE_TOP_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define QVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define QVR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/qvr_pkg.sv =====
// Shared widths and stage counts for the quaternion vector rotate block.
// No dependencies; used by the top level and the checker.
package qvr_pkg;

  // component width of every input and output field
  localparam int CW = 16;
  // squared length and first product components
  localparam int NW = 2 * CW + 1;
  localparam int TW = 2 * CW + 1;
  // second product terms and sums
  localparam int PRW = TW + CW;
  localparam int PW = 3 * CW + 2;
  // divider remainder and divisor
  localparam int RW = PW + 2;
  localparam int DW = NW + 1;
  // pipeline depth: five arithmetic stages, CW+1 divider stages, output
  localparam int NS = CW + 7;
  // stream data widths, padded to whole bytes
  localparam int IN_DW = ((7 * CW + 7) / 8) * 8;
  localparam int OUT_DW = ((3 * CW + 7) / 8) * 8;
  localparam int OUT_UW = 2;
  // tuser bit positions
  localparam int U_SAT = 0;
  localparam int U_ZERO = 1;

endpackage

// ===== rtl/quaternion_vector_rotate_top.sv =====
// Quaternion vector rotation r = q * (0,v) * q^-1, fully pipelined.
// Depends on qvr_pkg.
//
// Usage:
//   Input stream in_*: one transfer carries the quaternion (w,x,y,z, Q1.14)
//   and the vector (x,y,z), all signed 16-bit. Output stream out_*: one
//   transfer per input with the rotated vector, rounded to nearest and
//   saturated, plus flags in tuser (saturated, zero quaternion).
//   Pipeline: five multiply/add stages, seventeen restoring divider stages
//   (an overflow check, then one quotient bit each for the three
//   components) and the output register.
//   Throughput: one item per cycle while out_tready is high; every stage
//   holds its own valid bit.
//   Reset clears all valid bits; payload registers keep whatever they hold.
//   When the receiver stalls, each stage holds its item while the stages
//   behind it keep filling empty slots, so in_tready stays high until the
//   whole pipeline is full. Nothing is lost or repeated.
//   A zero quaternion gives a zero vector with the zero flag set.
module quaternion_vector_rotate_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
  input  logic [qvr_pkg::IN_DW-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // rot_x, rot_y, rot_z
  output logic [qvr_pkg::OUT_DW-1:0]  out_tdata,
  // saturated, zero_quat
  output logic [qvr_pkg::OUT_UW-1:0]  out_tuser
);

  localparam int CW = qvr_pkg::CW;
  localparam int NS = qvr_pkg::NS;
  localparam int NW = qvr_pkg::NW;
  localparam int TW = qvr_pkg::TW;
  localparam int PRW = qvr_pkg::PRW;
  localparam int PW = qvr_pkg::PW;
  localparam int RW = qvr_pkg::RW;
  localparam int DW = qvr_pkg::DW;
  localparam int DS = 5;   // first divider stage

  // stage valid bits and load enables
  logic [NS-1:0] v_r, v_nxt;
  logic [NS:0]   adv;

  assign adv[NS] = out_tready;
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end

  assign in_tready = adv[0];
  assign out_tvalid = v_r[NS-1];

  // advance valid bits
  always_comb begin
    v_nxt = v_r;
    if (adv[0]) begin
      v_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // unpack input fields
  logic signed [CW-1:0] qw, qx, qy, qz, vx, vy, vz;
  assign qw = in_tdata[0*CW +: CW];
  assign qx = in_tdata[1*CW +: CW];
  assign qy = in_tdata[2*CW +: CW];
  assign qz = in_tdata[3*CW +: CW];
  assign vx = in_tdata[4*CW +: CW];
  assign vy = in_tdata[5*CW +: CW];
  assign vz = in_tdata[6*CW +: CW];

  // stage 0: products of q with (0,v) and squares of q
  logic signed [2*CW-1:0] pa_r [9];
  logic signed [2*CW-1:0] pa_nxt [9];
  logic signed [2*CW-1:0] sq_r [4];
  logic signed [2*CW-1:0] sq_nxt [4];
  logic signed [CW-1:0]   q0_r [4];

  always_comb begin
    pa_nxt[0] = qx * vx;
    pa_nxt[1] = qy * vy;
    pa_nxt[2] = qz * vz;
    pa_nxt[3] = qw * vx;
    pa_nxt[4] = qy * vz;
    pa_nxt[5] = qz * vy;
    pa_nxt[6] = qw * vy;
    pa_nxt[7] = qx * vz;
    pa_nxt[8] = qz * vx;
    sq_nxt[0] = qw * qw;
    sq_nxt[1] = qx * qx;
    sq_nxt[2] = qy * qy;
    sq_nxt[3] = qz * qz;
  end

  logic signed [2*CW-1:0] pa_wv;
  assign pa_wv = qw * vz;
  logic signed [2*CW-1:0] pa_xv;
  assign pa_xv = qx * vy;
  logic signed [2*CW-1:0] pa_yv;
  assign pa_yv = qy * vx;

  logic signed [2*CW-1:0] pb_r [3];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pa_r <= pa_nxt;
      sq_r <= sq_nxt;
      pb_r[0] <= pa_wv;
      pb_r[1] <= pa_xv;
      pb_r[2] <= pa_yv;
      q0_r[0] <= qw;
      q0_r[1] <= qx;
      q0_r[2] <= qy;
      q0_r[3] <= qz;
    end
  end

  // stage 1: sum into t = q * (0,v) and the squared length
  logic signed [TW-1:0] t_r [4];
  logic signed [TW-1:0] t_nxt [4];
  logic [NW-1:0]        n1_r, n1_nxt;
  logic signed [CW-1:0] q1_r [4];

  always_comb begin
    t_nxt[0] = -TW'(pa_r[0]) - TW'(pa_r[1]) - TW'(pa_r[2]);
    t_nxt[1] = TW'(pa_r[3]) + TW'(pa_r[4]) - TW'(pa_r[5]);
    t_nxt[2] = TW'(pa_r[6]) - TW'(pa_r[7]) + TW'(pa_r[8]);
    t_nxt[3] = TW'(pb_r[0]) + TW'(pb_r[1]) - TW'(pb_r[2]);
    n1_nxt = NW'($unsigned(sq_r[0])) + NW'($unsigned(sq_r[1])) +
             NW'($unsigned(sq_r[2])) + NW'($unsigned(sq_r[3]));
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      t_r  <= t_nxt;
      n1_r <= n1_nxt;
      q1_r <= q0_r;
    end
  end

  // stage 2: products of t with the conjugate of q
  logic signed [PRW-1:0] pr_r [12];
  logic signed [PRW-1:0] pr_nxt [12];
  logic [NW-1:0]         n2_r;

  always_comb begin
    pr_nxt[0]  = t_r[0] * q1_r[1];
    pr_nxt[1]  = t_r[1] * q1_r[0];
    pr_nxt[2]  = t_r[2] * q1_r[3];
    pr_nxt[3]  = t_r[3] * q1_r[2];
    pr_nxt[4]  = t_r[0] * q1_r[2];
    pr_nxt[5]  = t_r[1] * q1_r[3];
    pr_nxt[6]  = t_r[2] * q1_r[0];
    pr_nxt[7]  = t_r[3] * q1_r[1];
    pr_nxt[8]  = t_r[0] * q1_r[3];
    pr_nxt[9]  = t_r[1] * q1_r[2];
    pr_nxt[10] = t_r[2] * q1_r[1];
    pr_nxt[11] = t_r[3] * q1_r[0];
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      pr_r <= pr_nxt;
      n2_r <= n1_r;
    end
  end

  // stage 3: vector part of t * conj(q)
  logic signed [PW-1:0] r_r [3];
  logic signed [PW-1:0] r_nxt [3];
  logic [NW-1:0]        n3_r;
  logic                 z3_r;

  always_comb begin
    r_nxt[0] = -PW'(pr_r[0]) + PW'(pr_r[1]) - PW'(pr_r[2]) + PW'(pr_r[3]);
    r_nxt[1] = -PW'(pr_r[4]) + PW'(pr_r[5]) + PW'(pr_r[6]) - PW'(pr_r[7]);
    r_nxt[2] = -PW'(pr_r[8]) - PW'(pr_r[9]) + PW'(pr_r[10]) + PW'(pr_r[11]);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      r_r  <= r_nxt;
      n3_r <= n2_r;
      z3_r <= (n2_r == '0);
    end
  end

  // stage 4: magnitude, rounding offset and divisor
  logic [RW-1:0] num_r [3];
  logic [RW-1:0] num_nxt [3];
  logic [2:0]    neg4_r;
  logic [DW-1:0] den4_r;
  logic          z4_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_nxt[c] = RW'(r_r[c][PW-1] ? -r_r[c] : r_r[c]) << 1;
      num_nxt[c] = num_nxt[c] + RW'(n3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      num_r  <= num_nxt;
      neg4_r <= {r_r[2][PW-1], r_r[1][PW-1], r_r[0][PW-1]};
      den4_r <= {n3_r, 1'b0};
      z4_r   <= z3_r;
    end
  end

  // divider: stage 0 checks for overflow, then one quotient bit per stage
  logic [RW-1:0] dv_rem_r [CW+1][3];
  logic [CW-1:0] dv_q_r   [CW+1][3];
  logic [2:0]    dv_ovf_r [CW+1];
  logic [2:0]    dv_neg_r [CW+1];
  logic [DW-1:0] dv_den_r [CW+1];
  logic          dv_z_r   [CW+1];

  for (genvar j = 0; j <= CW; j++) begin : g_div
    localparam int SH = (j == 0) ? CW : CW - j;
    logic [RW-1:0] rem_in [3];
    logic [CW-1:0] q_in [3];
    logic [2:0]    ovf_in, neg_in;
    logic [DW-1:0] den_in;
    logic          z_in;
    logic [RW-1:0] sub;
    logic [RW-1:0] rem_nxt [3];
    logic [CW-1:0] q_nxt [3];
    logic [2:0]    ovf_nxt;

    if (j == 0) begin : g_first
      assign rem_in = num_r;
      assign q_in = '{default: '0};
      assign ovf_in = '0;
      assign neg_in = neg4_r;
      assign den_in = den4_r;
      assign z_in = z4_r;
    end else begin : g_next
      assign rem_in = dv_rem_r[j-1];
      assign q_in = dv_q_r[j-1];
      assign ovf_in = dv_ovf_r[j-1];
      assign neg_in = dv_neg_r[j-1];
      assign den_in = dv_den_r[j-1];
      assign z_in = dv_z_r[j-1];
    end

    assign sub = RW'(den_in) << SH;

    // compare and subtract the shifted divisor
    always_comb begin
      ovf_nxt = ovf_in;
      for (int c = 0; c < 3; c++) begin
        rem_nxt[c] = rem_in[c];
        q_nxt[c] = q_in[c];
        if (j == 0) begin
          ovf_nxt[c] = (rem_in[c] >= sub);
        end else begin
          q_nxt[c] = {q_in[c][CW-2:0], (rem_in[c] >= sub)};
          if (rem_in[c] >= sub) begin
            rem_nxt[c] = rem_in[c] - sub;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[DS+j]) begin
        dv_rem_r[j] <= rem_nxt;
        dv_q_r[j]   <= q_nxt;
        dv_ovf_r[j] <= ovf_nxt;
        dv_neg_r[j] <= neg_in;
        dv_den_r[j] <= den_in;
        dv_z_r[j]   <= z_in;
      end
    end
  end

  // output stage: sign, saturation and zero override
  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] NEGM = {1'b1, {(CW-1){1'b0}}};

  logic [CW-1:0] rot_nxt [3];
  logic [2:0]    clip;
  logic [CW-1:0] rot_r [3];
  logic          sat_r, zq_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dv_neg_r[CW][c]) begin
        clip[c] = dv_ovf_r[CW][c] || (dv_q_r[CW][c] > NEGM);
        rot_nxt[c] = clip[c] ? NEGM : -dv_q_r[CW][c];
      end else begin
        clip[c] = dv_ovf_r[CW][c] || (dv_q_r[CW][c] > MAXV);
        rot_nxt[c] = clip[c] ? MAXV : dv_q_r[CW][c];
      end
      if (dv_z_r[CW]) begin
        rot_nxt[c] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      rot_r <= rot_nxt;
      sat_r <= !dv_z_r[CW] && (clip != '0);
      zq_r  <= dv_z_r[CW];
    end
  end

  assign out_tdata = qvr_pkg::OUT_DW'({rot_r[2], rot_r[1], rot_r[0]});
  assign out_tuser[qvr_pkg::U_SAT] = sat_r;
  assign out_tuser[qvr_pkg::U_ZERO] = zq_r;

endmodule

// ===== rtl/qvr_checker.sv =====
// Port-level checker for the quaternion vector rotate top level, with its bind.
// Depends on qvr_pkg and quaternion_vector_rotate_top_macros.svh.
`include "quaternion_vector_rotate_top_macros.svh"

module qvr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [qvr_pkg::OUT_DW-1:0]  out_tdata,
  input logic [qvr_pkg::OUT_UW-1:0]  out_tuser
);

  localparam int CW = qvr_pkg::CW;
  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] NEGM = {1'b1, {(CW-1){1'b0}}};

  logic [CW-1:0] rx, ry, rz;
  logic          sat, zq;
  assign rx = out_tdata[0*CW +: CW];
  assign ry = out_tdata[1*CW +: CW];
  assign rz = out_tdata[2*CW +: CW];
  assign sat = out_tuser[qvr_pkg::U_SAT];
  assign zq = out_tuser[qvr_pkg::U_ZERO];

  // hold a stalled result
  `QVR_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // a zero quaternion gives a clean zero vector
  `QVR_ASSERT(a_zero, out_tvalid && zq |-> (out_tdata == '0) && !sat, "zero quaternion result not zero")

  // a clipped result sits on a bound
  `QVR_ASSERT(a_sat, out_tvalid && sat |-> rx == MAXV || rx == NEGM || ry == MAXV || ry == NEGM || rz == MAXV || rz == NEGM, "saturated flag without bound value")

  // drop the output after reset
  `QVR_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_tvalid, "output valid right after reset")

endmodule

bind quaternion_vector_rotate_top qvr_checker u_qvr_checker (.*);

// ===== verif/tb.sv =====
// Testbench for quaternion_vector_rotate_top: directed and random rotations
// checked against an in-bench predictor. Depends on qvr_pkg and the top level.

class rotate_scoreboard;
  typedef struct {
    logic [15:0] rx, ry, rz;
    logic        sat, zq;
  } rot_result_t;

  rot_result_t pending[$];
  int errors = 0;
  int checked = 0;
  int sat_seen = 0;
  int zero_seen = 0;

  // round num/den to nearest, ties away from zero, then clip to 16 bits
  function automatic logic [15:0] round_clip(longint num, longint den, ref logic sat);
    longint mag, q;
    logic neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (2 * mag + den) / (2 * den);
    if (neg) begin
      if (q > 32768) begin
        q = 32768;
        sat = 1'b1;
      end
      q = -q;
    end else if (q > 32767) begin
      q = 32767;
      sat = 1'b1;
    end
    return q[15:0];
  endfunction

  // work out the rotated vector for one accepted transfer
  function void note_input(logic [111:0] d);
    longint w, x, y, z, vx, vy, vz, n;
    longint tw, tx, ty, tz, px, py, pz;
    rot_result_t r;
    w = $signed(d[15:0]);   x = $signed(d[31:16]);
    y = $signed(d[47:32]);  z = $signed(d[63:48]);
    vx = $signed(d[79:64]); vy = $signed(d[95:80]); vz = $signed(d[111:96]);
    n = w * w + x * x + y * y + z * z;
    r.sat = 1'b0;
    if (n == 0) begin
      r.rx = '0; r.ry = '0; r.rz = '0; r.zq = 1'b1;
    end else begin
      // t = q * (0,v)
      tw = -x * vx - y * vy - z * vz;
      tx = w * vx + y * vz - z * vy;
      ty = w * vy - x * vz + z * vx;
      tz = w * vz + x * vy - y * vx;
      // t * conj(q), vector part
      px = -tw * x + tx * w - ty * z + tz * y;
      py = -tw * y + tx * z + ty * w - tz * x;
      pz = -tw * z - tx * y + ty * x + tz * w;
      r.rx = round_clip(px, n, r.sat);
      r.ry = round_clip(py, n, r.sat);
      r.rz = round_clip(pz, n, r.sat);
      r.zq = 1'b0;
    end
    pending.push_back(r);
  endfunction

  function void check_result(logic [47:0] d, logic [1:0] u);
    rot_result_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected transfer data=%h user=%b", d, u);
      return;
    end
    e = pending.pop_front();
    checked++;
    if (u[qvr_pkg::U_SAT]) sat_seen++;
    if (u[qvr_pkg::U_ZERO]) zero_seen++;
    if (d[15:0] !== e.rx || d[31:16] !== e.ry || d[47:32] !== e.rz ||
        u[qvr_pkg::U_SAT] !== e.sat || u[qvr_pkg::U_ZERO] !== e.zq) begin
      errors++;
      if (errors <= 10)
        $display("mismatch #%0d: exp x=%h y=%h z=%h sat=%b zero=%b, got x=%h y=%h z=%h user=%b",
                 checked, e.rx, e.ry, e.rz, e.sat, e.zq,
                 d[15:0], d[31:16], d[47:32], u);
    end
  endfunction
endclass

module tb;
  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [qvr_pkg::IN_DW-1:0]  in_tdata;
  logic [qvr_pkg::OUT_DW-1:0] out_tdata;
  logic [qvr_pkg::OUT_UW-1:0] out_tuser;

  rotate_scoreboard sb;
  int cycles = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  localparam int CYCLE_LIMIT = 200000;

  quaternion_vector_rotate_top dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      mode = (cycles / 300) % 3;
      if (hold_off) out_tready <= 0;
      else if (mode == 0) out_tready <= 1;
      else if (mode == 1) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= ($urandom_range(0, 1) == 0);
    end
  end

  // pick a field value that favors extremes
  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'(int'($urandom_range(0, 32)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one item and hold it until it transfers
  task automatic send_item(logic [111:0] d);
    in_tdata <= d;
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_gap();
    in_tvalid <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // random item: Q1.14 quaternion with components within +-1.0 most of the time
  function automatic logic [111:0] rand_item();
    logic [15:0] q[4];
    logic [15:0] v[3];
    int sel;
    sel = $urandom_range(0, 3);
    foreach (q[i]) q[i] = (sel == 0) ? pick_comp() : 16'(int'($urandom_range(0, 32768)) - 16384);
    if ($urandom_range(0, 40) == 0) foreach (q[i]) q[i] = '0;
    foreach (v[i]) v[i] = pick_comp();
    return {v[2], v[1], v[0], q[3], q[2], q[1], q[0]};
  endfunction

  initial begin
    int burst;
    sb = new();
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: identity, zero quaternion, extremes, saturation, rounding
    send_item({16'd3, 16'hfffe, 16'd1, 16'd0, 16'd0, 16'd0, 16'sd16384});
    send_item({16'h7fff, 16'h8000, 16'd5, 16'd0, 16'd0, 16'd0, 16'd0});
    send_item({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_item({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    send_item({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    send_item({16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0001});
    send_item({16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001});
    send_item({16'h0000, 16'h0001, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0002});
    send_item({16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'h0001, 16'h0001});
    send_item({16'h1234, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0001, 16'h0000});
    send_item({16'h0003, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0000});
    send_item({16'h5555, 16'haaaa, 16'h5555, 16'h2d41, 16'h0000, 16'h0000, 16'h2d41});
    send_gap();

    // long receiver hold-off while items keep coming
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      repeat (60) send_item(rand_item());
    join
    send_gap();

    // random bursts
    for (int n = 0; n < 1600; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) send_item(rand_item());
      n += burst;
      if ($urandom_range(0, 2) != 0) send_gap();
    end
    in_tvalid <= 0;
    stim_done = 1;
  end

  // finish once everything has drained, or on timeout
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
    repeat (40) @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", sb.pending.size());
      $display("RESULT: ERROR");
    end else begin
      $display("checked %0d rotations (%0d clipped, %0d zero quaternions), %0d errors",
               sb.checked, sb.sat_seen, sb.zero_seen, sb.errors);
      if (sb.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
    end
    $finish;
  end

  // hard stop if the drain never starts
  initial begin
    wait (cycles >= CYCLE_LIMIT + 100);
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== quaternion_vector_rotate_top.f =====
+incdir+rtl
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate_top.sv
rtl/qvr_checker.sv
verif/tb.sv
